// ===== hdl/tvvs_pkg.sv =====
// Shared constants and types for the triangle control-volume split core
package tvvs_pkg;
    localparam int CFG_W       = 32;
    localparam int SHARE_W     = 48;
    localparam int QUO_W       = 48;
    localparam int LANES       = 3;
    localparam int ROUND_SHIFT = 11;
    localparam int DEGEN_SHIFT = 31;

    localparam logic [SHARE_W-1:0] SHARE_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [SHARE_W-1:0] SHARE_NEG_MAG = 48'h8000_0000_0000;

    typedef struct packed {
        logic [LANES-1:0] ovf;
        logic [LANES-1:0] neg;
        logic             degen;
    } t_div_flags;
endpackage

// ===== hdl/tvvs_geom.sv =====
// Geometry pipeline: edges, cross product squared norm, edge dot products, per-vertex numerators
module tvvs_geom #(
    parameter int W = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [W-1:0]               i_p [3][3],
    input  logic [tvvs_pkg::CFG_W-1:0]        i_limit,
    output logic                              o_valid,
    output logic [4*W+7:0]                    o_s,
    output logic [4*W+4:0]                    o_m [tvvs_pkg::LANES],
    output logic [tvvs_pkg::LANES-1:0]        o_neg,
    output logic                              o_degen
);
    localparam int EW  = W + 1;
    localparam int PW  = 2*W + 2;
    localparam int CW  = 2*W + 3;
    localparam int DSW = 2*W + 4;
    localparam int LW  = 2*W + 2;
    localparam int HX  = W + 2;
    localparam int HL  = W + 1;
    localparam int PHH = 2*W + 2;
    localparam int PHL = 2*W + 3;
    localparam int PLL = 2*W + 4;
    localparam int PT  = 2*W + 2;
    localparam int SQW = 4*W + 6;
    localparam int SW  = 4*W + 8;
    localparam int TW  = 4*W + 4;
    localparam int NW  = 4*W + 6;
    localparam int MW  = 4*W + 5;
    localparam int DGW = SW - tvvs_pkg::DEGEN_SHIFT;

    logic [7:0] r_v;

    logic signed [EW-1:0]  r_e  [3][3];
    logic signed [EW-1:0]  n_e  [3][3];
    logic signed [PW-1:0]  r_cp [6];
    logic signed [PW-1:0]  n_cp [6];
    logic signed [PW-1:0]  r_dp [6][3];
    logic signed [PW-1:0]  n_dp [6][3];
    logic signed [CW-1:0]  x_diff [3];
    logic signed [DSW-1:0] d_sum [6];
    logic signed [DSW-1:0] d_abs [3];
    logic [CW-1:0]         r_xm [3];
    logic [CW-1:0]         n_xm [3];
    logic [LW-1:0]         r_l2 [3];
    logic [LW-1:0]         n_l2 [3];
    logic [LW-1:0]         r_dm [3];
    logic [LW-1:0]         n_dm [3];
    logic [2:0]            r_dn3, n_dn3;
    logic [PHH-1:0]        r_xhh [3];
    logic [PHH-1:0]        n_xhh [3];
    logic [PHL-1:0]        r_xhl [3];
    logic [PHL-1:0]        n_xhl [3];
    logic [PLL-1:0]        r_xll [3];
    logic [PLL-1:0]        n_xll [3];
    logic [PT-1:0]         r_thh [3];
    logic [PT-1:0]         n_thh [3];
    logic [PT-1:0]         r_thl [3];
    logic [PT-1:0]         n_thl [3];
    logic [PT-1:0]         r_tlh [3];
    logic [PT-1:0]         n_tlh [3];
    logic [PT-1:0]         r_tll [3];
    logic [PT-1:0]         n_tll [3];
    logic [2:0]            r_dn4;
    logic [SQW-1:0]        r_sq [3];
    logic [SQW-1:0]        n_sq [3];
    logic [TW-1:0]         r_tm [3];
    logic [TW-1:0]         n_tm [3];
    logic [2:0]            r_dn5;
    logic [SW-1:0]         r_s6, n_s6;
    logic signed [TW:0]    r_ts [3];
    logic signed [TW:0]    n_ts [3];
    logic [SW-1:0]         r_s7;
    logic signed [NW-1:0]  r_n [3];
    logic signed [NW-1:0]  n_n [3];
    logic                  r_dg7, n_dg7;
    logic [SW-1:0]         r_s8;
    logic [MW-1:0]         r_m [3];
    logic [MW-1:0]         n_m [3];
    logic [2:0]            r_neg8, n_neg8;
    logic                  r_dg8;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_e[0][c] = EW'(i_p[1][c]) - EW'(i_p[0][c]);
            n_e[1][c] = EW'(i_p[2][c]) - EW'(i_p[0][c]);
            n_e[2][c] = EW'(i_p[2][c]) - EW'(i_p[1][c]);
        end
    end

    always_comb begin
        n_cp[0] = PW'(r_e[0][1]) * PW'(r_e[1][2]);
        n_cp[1] = PW'(r_e[0][2]) * PW'(r_e[1][1]);
        n_cp[2] = PW'(r_e[0][2]) * PW'(r_e[1][0]);
        n_cp[3] = PW'(r_e[0][0]) * PW'(r_e[1][2]);
        n_cp[4] = PW'(r_e[0][0]) * PW'(r_e[1][1]);
        n_cp[5] = PW'(r_e[0][1]) * PW'(r_e[1][0]);
        for (int c = 0; c < 3; c++) begin
            n_dp[0][c] = PW'(r_e[0][c]) * PW'(r_e[0][c]);
            n_dp[1][c] = PW'(r_e[1][c]) * PW'(r_e[1][c]);
            n_dp[2][c] = PW'(r_e[2][c]) * PW'(r_e[2][c]);
            n_dp[3][c] = PW'(r_e[1][c]) * PW'(r_e[2][c]);
            n_dp[4][c] = PW'(r_e[0][c]) * PW'(r_e[2][c]);
            n_dp[5][c] = PW'(r_e[0][c]) * PW'(r_e[1][c]);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            x_diff[c] = CW'(r_cp[2*c]) - CW'(r_cp[2*c+1]);
            n_xm[c]   = x_diff[c][CW-1] ? CW'(-x_diff[c]) : CW'(x_diff[c]);
        end
        for (int k = 0; k < 6; k++) begin
            d_sum[k] = DSW'(r_dp[k][0]) + DSW'(r_dp[k][1]) + DSW'(r_dp[k][2]);
        end
        for (int j = 0; j < 3; j++) begin
            n_l2[j]  = LW'(d_sum[j]);
            d_abs[j] = d_sum[j+3][DSW-1] ? -d_sum[j+3] : d_sum[j+3];
            n_dm[j]  = LW'(d_abs[j]);
        end
        n_dn3[0] = d_sum[3][DSW-1];
        n_dn3[1] = ~d_sum[4][DSW-1];
        n_dn3[2] = d_sum[5][DSW-1];
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_xhh[c] = PHH'(r_xm[c][CW-1:HX]) * PHH'(r_xm[c][CW-1:HX]);
            n_xhl[c] = PHL'(r_xm[c][CW-1:HX]) * PHL'(r_xm[c][HX-1:0]);
            n_xll[c] = PLL'(r_xm[c][HX-1:0]) * PLL'(r_xm[c][HX-1:0]);
            n_thh[c] = PT'(r_l2[c][LW-1:HL]) * PT'(r_dm[c][LW-1:HL]);
            n_thl[c] = PT'(r_l2[c][LW-1:HL]) * PT'(r_dm[c][HL-1:0]);
            n_tlh[c] = PT'(r_l2[c][HL-1:0]) * PT'(r_dm[c][LW-1:HL]);
            n_tll[c] = PT'(r_l2[c][HL-1:0]) * PT'(r_dm[c][HL-1:0]);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sq[c] = (SQW'(r_xhh[c]) << (2*HX)) + (SQW'(r_xhl[c]) << (HX+1))
                    + SQW'(r_xll[c]);
            n_tm[c] = (TW'(r_thh[c]) << (2*HL)) + ((TW'(r_thl[c]) + TW'(r_tlh[c])) << HL)
                    + TW'(r_tll[c]);
        end
    end

    always_comb begin
        n_s6 = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
        for (int c = 0; c < 3; c++) begin
            n_ts[c] = r_dn5[c] ? -$signed({1'b0, r_tm[c]}) : $signed({1'b0, r_tm[c]});
        end
    end

    always_comb begin
        n_n[0] = NW'(r_ts[0]) + NW'(r_ts[1]);
        n_n[1] = NW'(r_ts[0]) + NW'(r_ts[2]);
        n_n[2] = NW'(r_ts[1]) + NW'(r_ts[2]);
        n_dg7  = r_s6[SW-1:tvvs_pkg::DEGEN_SHIFT] <= DGW'(i_limit);
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_m[c]    = r_n[c][NW-1] ? MW'(-r_n[c]) : MW'(r_n[c]);
            n_neg8[c] = r_n[c][NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e    <= n_e;
            r_cp   <= n_cp;
            r_dp   <= n_dp;
            r_xm   <= n_xm;
            r_l2   <= n_l2;
            r_dm   <= n_dm;
            r_dn3  <= n_dn3;
            r_xhh  <= n_xhh;
            r_xhl  <= n_xhl;
            r_xll  <= n_xll;
            r_thh  <= n_thh;
            r_thl  <= n_thl;
            r_tlh  <= n_tlh;
            r_tll  <= n_tll;
            r_dn4  <= r_dn3;
            r_sq   <= n_sq;
            r_tm   <= n_tm;
            r_dn5  <= r_dn4;
            r_s6   <= n_s6;
            r_ts   <= n_ts;
            r_s7   <= r_s6;
            r_n    <= n_n;
            r_dg7  <= n_dg7;
            r_s8   <= r_s7;
            r_m    <= n_m;
            r_neg8 <= n_neg8;
            r_dg8  <= r_dg7;
        end
    end

    assign o_valid = r_v[7];
    assign o_s     = r_s8;
    assign o_m     = r_m;
    assign o_neg   = r_neg8;
    assign o_degen = r_dg8;
endmodule

// ===== hdl/tvvs_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with sideband
module tvvs_isqrt #(
    parameter int IW  = 136,
    parameter int SBW = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [IW-1:0]            i_x,
    input  logic [SBW-1:0]           i_sb,
    output logic                     o_valid,
    output logic [(IW+1)/2-1:0]      o_root,
    output logic [SBW-1:0]           o_sb
);
    localparam int RW = (IW + 1) / 2;
    localparam int AW = RW + 4;
    localparam int XW = 2 * RW;

    logic [AW-1:0]  r_rem  [RW];
    logic [RW-1:0]  r_root [RW];
    logic [XW-1:0]  r_x    [RW];
    logic [SBW-1:0] r_sb   [RW];
    logic [RW-1:0]  r_v;

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [AW-1:0]  rem_q, rem_in, trial, n_rem;
        logic [RW-1:0]  root_q, n_root;
        logic [XW-1:0]  x_q;
        logic [SBW-1:0] sb_q;
        logic           ge;

        if (k == 0) begin : g_first
            assign rem_q  = '0;
            assign root_q = '0;
            assign x_q    = XW'(i_x);
            assign sb_q   = i_sb;
        end else begin : g_next
            assign rem_q  = r_rem[k-1];
            assign root_q = r_root[k-1];
            assign x_q    = r_x[k-1];
            assign sb_q   = r_sb[k-1];
        end

        always_comb begin
            rem_in = {rem_q[AW-3:0], x_q[XW-1 -: 2]};
            trial  = AW'({root_q, 2'b01});
            ge     = rem_in >= trial;
            n_rem  = ge ? rem_in - trial : rem_in;
            n_root = {root_q[RW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_x[k]    <= x_q << 2;
                r_sb[k]   <= sb_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RW-2:0], i_valid};
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_sb    = r_sb[RW-1];
endmodule

// ===== hdl/tvvs_div.sv =====
// Pipelined rounding divider, three lanes sharing one root, one quotient bit per stage
module tvvs_div #(
    parameter int RW = 68,
    parameter int MW = 133
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [RW-1:0]                      i_root,
    input  logic [MW-1:0]                      i_m [tvvs_pkg::LANES],
    input  logic [tvvs_pkg::LANES-1:0]         i_neg,
    input  logic                               i_degen,
    output logic                               o_valid,
    output logic [tvvs_pkg::QUO_W-1:0]         o_q [tvvs_pkg::LANES],
    output tvvs_pkg::t_div_flags               o_flags
);
    localparam int LN   = tvvs_pkg::LANES;
    localparam int QW   = tvvs_pkg::QUO_W;
    localparam int DW   = RW + tvvs_pkg::ROUND_SHIFT + 1;
    localparam int NAW  = (MW + 1 > RW + tvvs_pkg::ROUND_SHIFT) ? MW + 1
                                                                : RW + tvvs_pkg::ROUND_SHIFT;
    localparam int NUMW = NAW + 1;
    localparam int REMW = DW + QW;
    localparam int CMPW = (NUMW > REMW) ? NUMW : REMW;

    logic [QW+1:0]             r_v;
    logic [NUMW-1:0]           r_num [LN];
    logic [NUMW-1:0]           n_num [LN];
    logic [DW-1:0]             r_d2a, n_d2a;
    tvvs_pkg::t_div_flags      r_fa, n_fa;
    logic [REMW-1:0]           r_remb [LN];
    logic [REMW-1:0]           n_remb [LN];
    logic [DW-1:0]             r_d2b;
    tvvs_pkg::t_div_flags      r_fb, n_fb;
    logic [REMW-1:0]           r_rem [QW][LN];
    logic [QW-1:0]             r_q   [QW][LN];
    logic [DW-1:0]             r_d2  [QW];
    tvvs_pkg::t_div_flags      r_f   [QW];

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            n_num[l] = NUMW'({i_m[l], 1'b0}) + (NUMW'(i_root) << tvvs_pkg::ROUND_SHIFT);
        end
        n_d2a      = DW'(i_root) << (tvvs_pkg::ROUND_SHIFT + 1);
        n_fa.ovf   = '0;
        n_fa.neg   = i_neg;
        n_fa.degen = i_degen;
    end

    always_comb begin
        n_fb = r_fa;
        for (int l = 0; l < LN; l++) begin
            n_fb.ovf[l] = CMPW'(r_num[l]) >= (CMPW'(r_d2a) << QW);
            n_remb[l]   = REMW'(r_num[l]);
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_bit
        logic [REMW-1:0]      rem_q [LN];
        logic [QW-1:0]        q_q   [LN];
        logic [DW-1:0]        d2_q;
        tvvs_pkg::t_div_flags f_q;
        logic [REMW-1:0]      tsh;
        logic [REMW-1:0]      n_rem [LN];
        logic [QW-1:0]        n_q   [LN];

        if (k == 0) begin : g_first
            assign rem_q = r_remb;
            assign d2_q  = r_d2b;
            assign f_q   = r_fb;
            always_comb begin
                for (int l = 0; l < LN; l++) begin
                    q_q[l] = '0;
                end
            end
        end else begin : g_next
            assign rem_q = r_rem[k-1];
            assign q_q   = r_q[k-1];
            assign d2_q  = r_d2[k-1];
            assign f_q   = r_f[k-1];
        end

        always_comb begin
            tsh = REMW'(d2_q) << (QW - 1 - k);
            for (int l = 0; l < LN; l++) begin
                n_rem[l] = (rem_q[l] >= tsh) ? rem_q[l] - tsh : rem_q[l];
                n_q[l]   = {q_q[l][QW-2:0], rem_q[l] >= tsh};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
                r_d2[k]  <= d2_q;
                r_f[k]   <= f_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_d2a  <= n_d2a;
            r_fa   <= n_fa;
            r_remb <= n_remb;
            r_d2b  <= r_d2a;
            r_fb   <= n_fb;
        end
    end

    assign o_valid = r_v[QW+1];
    assign o_q     = r_q[QW-1];
    assign o_flags = r_f[QW-1];
endmodule

// ===== hdl/triangle_voronoi_volume_split_core.sv =====
// Top level of the triangle circumcentric control-volume split core
//
// Input channel: i_valid / o_stall carry one triangle word, nine signed Q16.16
// vertex coordinates. Output channel: o_valid / i_stall carry the three signed
// Q24.24 vertex shares and the degenerate flag. A word moves on a rising edge
// with valid high and stall low.
// Throughput: one triangle per cycle while the output is not stalled.
// Pipeline from accept to o_valid: 8 geometry stages, 2*COORD_WIDTH+4 square-root
// stages (one root bit each), 2 divider set-up stages, 48 quotient stages (one bit
// each), output register.
// i_cfg_we writes degenerate_limit from i_cfg_wdata; write it only while idle.
// Reset (i_rst_n low, synchronous) drops every word in flight and clears the
// limit to zero.
// When the receiver stalls, the output register holds its word and one more
// word lands in a skid register; o_stall then rises and the whole pipeline
// freezes until the receiver takes the held word.
module triangle_voronoi_volume_split_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_WIDTH-1:0]       i_v0_x,
    input  logic signed [COORD_WIDTH-1:0]       i_v0_y,
    input  logic signed [COORD_WIDTH-1:0]       i_v0_z,
    input  logic signed [COORD_WIDTH-1:0]       i_v1_x,
    input  logic signed [COORD_WIDTH-1:0]       i_v1_y,
    input  logic signed [COORD_WIDTH-1:0]       i_v1_z,
    input  logic signed [COORD_WIDTH-1:0]       i_v2_x,
    input  logic signed [COORD_WIDTH-1:0]       i_v2_y,
    input  logic signed [COORD_WIDTH-1:0]       i_v2_z,
    input  logic                                i_cfg_we,
    input  logic [tvvs_pkg::CFG_W-1:0]          i_cfg_wdata,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [tvvs_pkg::SHARE_W-1:0] o_share_v0,
    output logic signed [tvvs_pkg::SHARE_W-1:0] o_share_v1,
    output logic signed [tvvs_pkg::SHARE_W-1:0] o_share_v2,
    output logic                                o_degenerate
);
    localparam int LN  = tvvs_pkg::LANES;
    localparam int SHW = tvvs_pkg::SHARE_W;
    localparam int SW  = 4*COORD_WIDTH + 8;
    localparam int RW  = (SW + 1) / 2;
    localparam int MW  = 4*COORD_WIDTH + 5;
    localparam int SBW = LN*MW + LN + 1;

    logic [tvvs_pkg::CFG_W-1:0]  r_limit;
    logic                        en;
    logic signed [COORD_WIDTH-1:0] p [3][3];

    logic                        geo_valid;
    logic [SW-1:0]               geo_s;
    logic [MW-1:0]               geo_m [LN];
    logic [LN-1:0]               geo_neg;
    logic                        geo_degen;

    logic                        sq_valid;
    logic [RW-1:0]               sq_root;
    logic [SBW-1:0]              sq_sb;
    logic [MW-1:0]               sq_m [LN];

    logic                        dv_valid;
    logic [tvvs_pkg::QUO_W-1:0]  dv_q [LN];
    tvvs_pkg::t_div_flags        dv_flags;

    logic                        take;
    logic [SHW-1:0]              mag [LN];
    logic [SHW-1:0]              lim [LN];
    logic [SHW-1:0]              pipe_share [LN];

    logic [SHW-1:0]              r_out_share [LN];
    logic [SHW-1:0]              n_out_share [LN];
    logic                        r_out_degen, n_out_degen;
    logic                        r_out_valid, n_out_valid;
    logic [SHW-1:0]              r_skid_share [LN];
    logic [SHW-1:0]              n_skid_share [LN];
    logic                        r_skid_degen, n_skid_degen;
    logic                        r_skid_valid, n_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    assign en      = ~r_skid_valid;
    assign o_stall = r_skid_valid;

    assign p[0][0] = i_v0_x;
    assign p[0][1] = i_v0_y;
    assign p[0][2] = i_v0_z;
    assign p[1][0] = i_v1_x;
    assign p[1][1] = i_v1_y;
    assign p[1][2] = i_v1_z;
    assign p[2][0] = i_v2_x;
    assign p[2][1] = i_v2_y;
    assign p[2][2] = i_v2_z;

    tvvs_geom #(.W(COORD_WIDTH)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_p     (p),
        .i_limit (r_limit),
        .o_valid (geo_valid),
        .o_s     (geo_s),
        .o_m     (geo_m),
        .o_neg   (geo_neg),
        .o_degen (geo_degen)
    );

    tvvs_isqrt #(.IW(SW), .SBW(SBW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (geo_valid),
        .i_x     (geo_s),
        .i_sb    ({geo_m[0], geo_m[1], geo_m[2], geo_neg, geo_degen}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_sb    (sq_sb)
    );

    assign sq_m[0] = sq_sb[SBW-1 -: MW];
    assign sq_m[1] = sq_sb[SBW-1-MW -: MW];
    assign sq_m[2] = sq_sb[SBW-1-2*MW -: MW];

    tvvs_div #(.RW(RW), .MW(MW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_m     (sq_m),
        .i_neg   (sq_sb[LN:1]),
        .i_degen (sq_sb[0]),
        .o_valid (dv_valid),
        .o_q     (dv_q),
        .o_flags (dv_flags)
    );

    assign take = en & dv_valid;

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            lim[l]        = dv_flags.neg[l] ? tvvs_pkg::SHARE_NEG_MAG
                                            : tvvs_pkg::SHARE_POS_MAX;
            mag[l]        = (dv_flags.ovf[l] || (dv_q[l] > lim[l])) ? lim[l] : dv_q[l];
            pipe_share[l] = dv_flags.degen ? '0 : (dv_flags.neg[l] ? -mag[l] : mag[l]);
        end
    end

    always_comb begin
        n_out_share  = r_out_share;
        n_out_degen  = r_out_degen;
        n_out_valid  = r_out_valid;
        n_skid_share = r_skid_share;
        n_skid_degen = r_skid_degen;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                n_out_share  = r_skid_share;
                n_out_degen  = r_skid_degen;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_share = pipe_share;
                n_out_degen = dv_flags.degen;
                n_out_valid = take;
            end
        end else if (take) begin
            n_skid_share = pipe_share;
            n_skid_degen = dv_flags.degen;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_share  <= n_out_share;
        r_out_degen  <= n_out_degen;
        r_skid_share <= n_skid_share;
        r_skid_degen <= n_skid_degen;
    end

    assign o_valid      = r_out_valid;
    assign o_share_v0   = r_out_share[0];
    assign o_share_v1   = r_out_share[1];
    assign o_share_v2   = r_out_share[2];
    assign o_degenerate = r_out_degen;
endmodule

// ===== hdl/tvvs_checker.sv =====
// Port-level checker for the triangle control-volume split core, with its bind
module tvvs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_stall,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic [tvvs_pkg::SHARE_W-1:0] o_share_v0,
    input logic [tvvs_pkg::SHARE_W-1:0] o_share_v1,
    input logic [tvvs_pkg::SHARE_W-1:0] o_share_v2,
    input logic                         o_degenerate
);
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output word held");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall raised without output backpressure");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_share_v0 == '0 && o_share_v1 == '0 && o_share_v2 == '0))
        else $error("degenerate word carries nonzero shares");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_share_v0) && $stable(o_share_v1)
            && $stable(o_share_v2) && $stable(o_degenerate)))
        else $error("stalled output word changed");
endmodule

bind triangle_voronoi_volume_split_core tvvs_checker u_checker (.*);
